>>> hdl/traffic_counter_history_assert.svh
// Assertion macros for the traffic counter history block.
// Used by the top-level module; needs clk and rst in scope.
`ifndef TRAFFIC_COUNTER_HISTORY_ASSERT_SVH
`define TRAFFIC_COUNTER_HISTORY_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define TCH_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define TCH_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tch_pkg.sv
// Package for the traffic counter history block.
// Holds word types, slot counts and shared constants; no dependencies.
package tch_pkg;

  localparam int DaySlots    = 30;
  localparam int MonthSlots  = 12;
  localparam int TopSlots    = 10;
  localparam int CounterBits = 32;

  localparam int RankW     = 4;

  localparam logic [7:0] BootSlackReset = 8'd5;
  localparam logic [RankW-1:0] RankNone = RankW'(TopSlots);

  typedef struct packed {
    logic [31:0] rx_count;
    logic [31:0] tx_count;
    logic [31:0] boot_time;
    logic [15:0] day_code;
    logic [11:0] month_code;
    logic        initial_req;
  } in_word_t;

  typedef struct packed {
    logic [63:0] total_rx_mib;
    logic [63:0] total_tx_mib;
    logic [63:0] day_rx_mib;
    logic [63:0] day_tx_mib;
    logic [63:0] month_rx_mib;
    logic [63:0] month_tx_mib;
    logic        rebooted;
    logic        day_rotated;
    logic        month_rotated;
    logic [3:0]  top_rank;
  } out_word_t;

  // Classified word passed from front to back.
  typedef struct packed {
    logic [63:0] rx_mib;
    logic [63:0] tx_mib;
    logic [15:0] day_code;
    logic [11:0] month_code;
    logic        rebooted;
  } job_t;

endpackage

>>> hdl/tch_front.sv
// Front part: reboot check, counter deltas and KiB carry.
// Depends on tch_pkg; feeds job words into tch_queue.
module tch_front
  import tch_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] boot_slack,
  input  in_word_t   in_word,
  input  logic       in_take,
  output job_t       job
);

  logic [CounterBits-1:0] last_rx, last_tx;
  logic [9:0]    rx_kib_rest, tx_kib_rest;
  logic [31:0]   last_boot;

  logic          reboot;
  logic [CounterBits-1:0] rx_now, tx_now, rx_base, tx_base, rx_d, tx_d;
  logic [10:0]   rx_kib, tx_kib;
  logic [63:0]   rx_mib, tx_mib;

  always_comb begin
    reboot = (in_word.boot_time >= 32'(boot_slack)) &&
             (last_boot < in_word.boot_time - 32'(boot_slack));
    rx_now = in_word.rx_count[CounterBits-1:0];
    tx_now = in_word.tx_count[CounterBits-1:0];
    rx_base = reboot ? '0 : last_rx;
    tx_base = reboot ? '0 : last_tx;
    // modular difference covers one wrap
    rx_d = in_word.initial_req ? '0 : rx_now - rx_base;
    tx_d = in_word.initial_req ? '0 : tx_now - tx_base;
    rx_kib = 11'(rx_kib_rest) + 11'(rx_d[19:10]);
    tx_kib = 11'(tx_kib_rest) + 11'(tx_d[19:10]);
    rx_mib = 64'(rx_d[CounterBits-1:20]) + 64'(rx_kib[10]);
    tx_mib = 64'(tx_d[CounterBits-1:20]) + 64'(tx_kib[10]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_rx <= '0;
      last_tx <= '0;
      rx_kib_rest <= '0;
      tx_kib_rest <= '0;
      last_boot <= '1;
    end else if (in_take) begin
      last_rx <= rx_now;
      last_tx <= tx_now;
      rx_kib_rest <= rx_kib[9:0];
      tx_kib_rest <= tx_kib[9:0];
      last_boot <= in_word.boot_time;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      job.rx_mib <= rx_mib;
      job.tx_mib <= tx_mib;
      job.day_code <= in_word.day_code;
      job.month_code <= in_word.month_code;
      job.rebooted <= reboot;
    end
  end

endmodule

>>> hdl/tch_queue.sv
// Two-entry queue between front and back parts.
// Depends on tch_pkg for the job word type.
module tch_queue
  import tch_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_word,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> hdl/tch_back.sv
// Back part: totals, day/month shift chains and the top-day table.
// Depends on tch_pkg; takes job words from tch_queue.
module tch_back
  import tch_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      out_valid,
  output out_word_t out_word,
  input  logic      out_take
);

  typedef enum logic [1:0] {ACC, RANK, SHOW} state_t;

  state_t state;
  logic [63:0] rx_total, tx_total;
  logic [63:0] day_rx   [DaySlots];
  logic [63:0] day_tx   [DaySlots];
  logic [15:0] day_tag  [DaySlots];
  logic [63:0] month_rx [MonthSlots];
  logic [63:0] month_tx [MonthSlots];
  logic [11:0] month_tag[MonthSlots];
  logic [63:0] top_rx   [TopSlots];
  logic [63:0] top_tx   [TopSlots];
  logic [15:0] top_tag  [TopSlots];
  logic [64:0] top_sum  [TopSlots];
  logic [64:0] closed_sum;
  logic        drot, mrot, reb;

  logic [63:0] d_rx0, d_tx0, m_rx0, m_tx0;
  logic [TopSlots-1:0] gt;
  logic [RankW-1:0]    rank;
  logic                found;

  assign job_pop = (state == ACC) && job_valid;
  assign out_valid = state == SHOW;

  always_comb begin
    d_rx0 = day_rx[0] + job.rx_mib;
    d_tx0 = day_tx[0] + job.tx_mib;
    m_rx0 = month_rx[0] + job.rx_mib;
    m_tx0 = month_tx[0] + job.tx_mib;
  end

  // first slot whose sum the closed day exceeds
  always_comb begin
    rank = RankNone;
    found = 1'b0;
    for (int i = 0; i < TopSlots; i++) begin
      gt[i] = closed_sum > top_sum[i];
      if (gt[i] && !found) begin
        rank = RankW'(i);
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ACC;
      rx_total <= '0;
      tx_total <= '0;
      for (int i = 0; i < DaySlots; i++) begin
        day_rx[i] <= '0;
        day_tx[i] <= '0;
        day_tag[i] <= '0;
      end
      for (int i = 0; i < MonthSlots; i++) begin
        month_rx[i] <= '0;
        month_tx[i] <= '0;
        month_tag[i] <= '0;
      end
      for (int i = 0; i < TopSlots; i++) begin
        top_rx[i] <= '0;
        top_tx[i] <= '0;
        top_tag[i] <= '0;
        top_sum[i] <= '0;
      end
      drot <= 1'b0;
      mrot <= 1'b0;
      reb <= 1'b0;
      closed_sum <= '0;
      out_word <= '0;
    end else begin
      unique case (state)
        ACC: begin
          if (job_valid) begin
            rx_total <= rx_total + job.rx_mib;
            tx_total <= tx_total + job.tx_mib;
            reb <= job.rebooted;
            drot <= day_tag[0] != job.day_code;
            mrot <= month_tag[0] != job.month_code;
            closed_sum <= 65'(d_rx0) + 65'(d_tx0);
            if (day_tag[0] != job.day_code) begin
              for (int i = DaySlots - 1; i >= 2; i--) begin
                day_rx[i] <= day_rx[i-1];
                day_tx[i] <= day_tx[i-1];
                day_tag[i] <= day_tag[i-1];
              end
              day_rx[1] <= d_rx0;
              day_tx[1] <= d_tx0;
              day_tag[1] <= day_tag[0];
              day_rx[0] <= '0;
              day_tx[0] <= '0;
              day_tag[0] <= job.day_code;
            end else begin
              day_rx[0] <= d_rx0;
              day_tx[0] <= d_tx0;
            end
            if (month_tag[0] != job.month_code) begin
              for (int i = MonthSlots - 1; i >= 2; i--) begin
                month_rx[i] <= month_rx[i-1];
                month_tx[i] <= month_tx[i-1];
                month_tag[i] <= month_tag[i-1];
              end
              month_rx[1] <= m_rx0;
              month_tx[1] <= m_tx0;
              month_tag[1] <= month_tag[0];
              month_rx[0] <= '0;
              month_tx[0] <= '0;
              month_tag[0] <= job.month_code;
            end else begin
              month_rx[0] <= m_rx0;
              month_tx[0] <= m_tx0;
            end
            state <= RANK;
          end
        end
        RANK: begin
          // insert the closed day and shift lower entries down
          if (drot && found) begin
            for (int i = 0; i < TopSlots; i++) begin
              if (RankW'(i) == rank) begin
                top_rx[i] <= day_rx[1];
                top_tx[i] <= day_tx[1];
                top_tag[i] <= day_tag[1];
                top_sum[i] <= closed_sum;
              end
            end
            for (int i = 1; i < TopSlots; i++) begin
              if (RankW'(i) > rank) begin
                top_rx[i] <= top_rx[i-1];
                top_tx[i] <= top_tx[i-1];
                top_tag[i] <= top_tag[i-1];
                top_sum[i] <= top_sum[i-1];
              end
            end
          end
          out_word.total_rx_mib <= rx_total;
          out_word.total_tx_mib <= tx_total;
          out_word.day_rx_mib <= day_rx[0];
          out_word.day_tx_mib <= day_tx[0];
          out_word.month_rx_mib <= month_rx[0];
          out_word.month_tx_mib <= month_tx[0];
          out_word.rebooted <= reb;
          out_word.day_rotated <= drot;
          out_word.month_rotated <= mrot;
          out_word.top_rank <= drot ? rank : RankNone;
          state <= SHOW;
        end
        SHOW: begin
          if (out_take) state <= ACC;
        end
        default: state <= ACC;
      endcase
    end
  end

endmodule

>>> hdl/traffic_counter_history.sv
// Top level of the traffic counter history block.
// Depends on tch_pkg, tch_front, tch_queue, tch_back and the assert header.
//
//  channel | valid    | stall    | word
//  input   | in_valid | in_stall | in_word (in_word_t)
//  output  | valid    | stall    | out_word (out_word_t)
//  config  | cfg_we   | -        | cfg_data (boot_slack)
//
// An item passes the back part's sequencer states in order (accumulate, rank,
// show), and the back part takes no new word until the last one is taken.
// The front part takes a word per cycle, while in_stall is low, into a two-entry queue.
// Reset (rst, synchronous) clears counters, history and tables at once.
// A stalled output holds the back part; the front keeps taking words until
// the queue, with the word still in the front register, would fill.
`include "traffic_counter_history_assert.svh"
module traffic_counter_history
  import tch_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [7:0] cfg_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      valid,
  input  logic      stall,
  output out_word_t out_word
);

  logic [7:0] boot_slack;
  logic       q_full, q_empty, q_pop, in_take;
  job_t       job, head;

  always_ff @(posedge clk) begin
    if (rst) boot_slack <= BootSlackReset;
    else if (cfg_we) boot_slack <= cfg_data;
  end

  // front result lands in the cycle after take
  logic push;
  always_ff @(posedge clk) begin
    if (rst) push <= 1'b0;
    else push <= in_take;
  end

  // leave room for a word still in the front register
  assign in_stall = q_full || (push && q_pop == 1'b0 && !q_empty);
  assign in_take  = in_valid && !in_stall;

  tch_front u_front (
    .clk, .rst, .boot_slack, .in_word, .in_take, .job
  );

  tch_queue u_queue (
    .clk, .rst, .push, .push_word(job), .pop(q_pop),
    .full(q_full), .empty(q_empty), .head
  );

  tch_back u_back (
    .clk, .rst, .job_valid(!q_empty), .job(head), .job_pop(q_pop),
    .out_valid(valid), .out_word, .out_take(valid && !stall)
  );

  `TCH_ASSERT_IMP(a_no_push_full, push, !q_full || q_pop, "push into full queue")
  `TCH_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "pop from empty queue")
  `TCH_ASSERT_NEXT(a_out_hold, valid && stall, valid && $stable(out_word), "output word moved")

endmodule
